FILE: hdl/arpc_pkg.sv
// Shared types and constants of the ARP cache table.
// Used by arpc_ctrl, arpc_datapath and arp_cache_table; depends on nothing.
`timescale 1ns / 1ps

package arpc_pkg;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int STATE_W = 2;
    localparam int MODE_W  = 2;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 16;
    localparam int SLOT_W  = 4;

    // Reset value of the pending timeout register
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10;

    // Register indexes
    localparam logic REG_PENDING_TIMEOUT = 1'b0;

    // Request kinds
    localparam logic [KIND_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_EXPIRE = 2'd2;

    // Update modes
    localparam logic [MODE_W-1:0] MODE_INSERT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND_ONLY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRY_HARD  = 2'd2;

    // Requested entry states
    localparam logic [STATE_W-1:0] NEW_PENDING = 2'd0;
    localparam logic [STATE_W-1:0] NEW_STABLE  = 2'd1;

    // Stored entry kinds
    localparam logic [KIND_W-1:0] ENT_EMPTY   = 2'd0;
    localparam logic [KIND_W-1:0] ENT_PENDING = 2'd1;
    localparam logic [KIND_W-1:0] ENT_STABLE  = 2'd2;
    localparam logic [KIND_W-1:0] ENT_STATIC  = 2'd3;

    // One table entry as stored in memory
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // latch request, clear accumulators, rewind address
        logic scan;    // read entry at address, advance address
        logic clear;   // write empty entry at address, advance address
        logic finish;  // write back and load result register
    } arpc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic addr_last;  // address counter sits on the last entry
        logic out_free;   // result register can take a new result
    } arpc_sts_t;

endpackage

FILE: hdl/arpc_ctrl.sv
// Controller state machine of the ARP cache table.
// Depends on arpc_pkg for the command and status structs.
`timescale 1ns / 1ps

module arpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  arpc_pkg::arpc_sts_t sts,
    output arpc_pkg::arpc_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence clear pass, scan, last compare and write-back
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/arpc_datapath.sv
// Datapath of the ARP cache table: entry memory, scan accumulators, result register.
// Depends on arpc_pkg; driven by arpc_ctrl through arpc_cmd_t.
`timescale 1ns / 1ps

module arpc_datapath #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  arpc_pkg::arpc_cmd_t           cmd,
    output arpc_pkg::arpc_sts_t           sts,
    input  logic [arpc_pkg::KIND_W-1:0]   req_kind,
    input  logic [arpc_pkg::IP_W-1:0]     req_ip,
    input  logic [arpc_pkg::MAC_W-1:0]    req_mac,
    input  logic [arpc_pkg::STATE_W-1:0]  req_state,
    input  logic [arpc_pkg::MODE_W-1:0]   req_mode,
    input  logic [arpc_pkg::TIME_W-1:0]   req_now,
    input  logic [arpc_pkg::TMO_W-1:0]    pending_timeout,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic                          out_resolved,
    output logic [arpc_pkg::MAC_W-1:0]    out_mac,
    output logic                          out_written,
    output logic [arpc_pkg::SLOT_W-1:0]   out_slot
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    // Entry memory
    arpc_pkg::entry_t mem [TABLE_ENTRIES];
    arpc_pkg::entry_t q_reg;

    // Request registers
    logic [arpc_pkg::KIND_W-1:0]  kind_reg;
    logic [arpc_pkg::IP_W-1:0]    ip_reg;
    logic [arpc_pkg::MAC_W-1:0]   mac_reg;
    logic [arpc_pkg::STATE_W-1:0] state_reg;
    logic [arpc_pkg::MODE_W-1:0]  mode_reg;
    logic [arpc_pkg::TIME_W-1:0]  now_reg;

    // Address and compare stage
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;
    logic          eval_valid_reg;
    logic [AW-1:0] eval_idx_reg;

    // Scan accumulators
    logic                          found_reg, found_next;
    logic [AW-1:0]                 found_idx_reg, found_idx_next;
    logic                          res_reg, res_next;
    logic [arpc_pkg::MAC_W-1:0]    fmac_reg, fmac_next;
    logic                          have_empty_reg, have_empty_next;
    logic [AW-1:0]                 empty_idx_reg, empty_idx_next;
    logic                          have_old_reg, have_old_next;
    logic [AW-1:0]                 old_idx_reg, old_idx_next;
    logic [arpc_pkg::TIME_W-1:0]   old_t_reg, old_t_next;
    logic                          expired_reg, expired_next;

    // Write port
    logic             we;
    logic [AW-1:0]    waddr;
    arpc_pkg::entry_t wdata;

    // Write-back selection and result
    logic                          expire_hit;
    logic [arpc_pkg::TIME_W-1:0]   age;
    logic                          upd_we;
    logic [AW-1:0]                 upd_idx;
    logic [arpc_pkg::KIND_W-1:0]   new_kind;
    logic [AW+3:0]                 found_ext;
    logic [AW+3:0]                 upd_ext;
    logic                          out_valid_reg;
    logic                          hit_reg, resolved_reg, written_reg;
    logic [arpc_pkg::MAC_W-1:0]    omac_reg;
    logic [arpc_pkg::SLOT_W-1:0]   slot_reg;
    logic                          hit_next, resolved_next, written_next;
    logic [arpc_pkg::MAC_W-1:0]    omac_next;
    logic [arpc_pkg::SLOT_W-1:0]   slot_next;

    assign sts.addr_last = (addr_reg == LAST_ADDR);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Advance address, wrap after the last entry
    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.start)
        begin
            addr_next = '0;
        end
        else if (cmd.scan || cmd.clear)
        begin
            addr_next = sts.addr_last ? '0 : addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            eval_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            eval_valid_reg <= cmd.scan;
        end
    end

    // Latch request and compare index
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg  <= req_kind;
            ip_reg    <= req_ip;
            mac_reg   <= req_mac;
            state_reg <= req_state;
            mode_reg  <= req_mode;
            now_reg   <= req_now;
        end
        if (cmd.scan)
        begin
            eval_idx_reg <= addr_reg;
        end
    end

    // Compare one entry per cycle against the request
    assign age        = now_reg - q_reg.stamp;
    assign expire_hit = eval_valid_reg && (kind_reg == arpc_pkg::REQ_EXPIRE)
                        && (q_reg.kind == arpc_pkg::ENT_PENDING)
                        && (age > {16'd0, pending_timeout});

    always_comb
    begin
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        res_next        = res_reg;
        fmac_next       = fmac_reg;
        have_empty_next = have_empty_reg;
        empty_idx_next  = empty_idx_reg;
        have_old_next   = have_old_reg;
        old_idx_next    = old_idx_reg;
        old_t_next      = old_t_reg;
        expired_next    = expired_reg;
        if (cmd.start)
        begin
            found_next      = 1'b0;
            found_idx_next  = '0;
            res_next        = 1'b0;
            fmac_next       = '0;
            have_empty_next = 1'b0;
            empty_idx_next  = '0;
            have_old_next   = 1'b0;
            old_idx_next    = '0;
            old_t_next      = '0;
            expired_next    = 1'b0;
        end
        else if (eval_valid_reg && !found_reg)
        begin
            case (kind_reg)
                arpc_pkg::REQ_LOOKUP:
                begin
                    if (q_reg.kind != arpc_pkg::ENT_EMPTY && q_reg.ip == ip_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = eval_idx_reg;
                        if (q_reg.kind == arpc_pkg::ENT_STABLE
                            || q_reg.kind == arpc_pkg::ENT_STATIC)
                        begin
                            res_next  = 1'b1;
                            fmac_next = q_reg.mac;
                        end
                    end
                end
                arpc_pkg::REQ_UPDATE:
                begin
                    if (q_reg.kind != arpc_pkg::ENT_STATIC)
                    begin
                        if (q_reg.kind != arpc_pkg::ENT_EMPTY && q_reg.ip == ip_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = eval_idx_reg;
                        end
                        else
                        begin
                            if (q_reg.kind == arpc_pkg::ENT_EMPTY && !have_empty_reg)
                            begin
                                have_empty_next = 1'b1;
                                empty_idx_next  = eval_idx_reg;
                            end
                            if (!have_old_reg || q_reg.stamp < old_t_reg)
                            begin
                                have_old_next = 1'b1;
                                old_t_next    = q_reg.stamp;
                                old_idx_next  = eval_idx_reg;
                            end
                        end
                    end
                end
                arpc_pkg::REQ_EXPIRE:
                begin
                    if (expire_hit)
                    begin
                        expired_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        res_reg        <= res_next;
        fmac_reg       <= fmac_next;
        have_empty_reg <= have_empty_next;
        empty_idx_reg  <= empty_idx_next;
        have_old_reg   <= have_old_next;
        old_idx_reg    <= old_idx_next;
        old_t_reg      <= old_t_next;
        expired_reg    <= expired_next;
    end

    // Pick the update target: match, else first empty unless find-only, else oldest in try-hard mode
    always_comb
    begin
        upd_we  = 1'b0;
        upd_idx = found_idx_reg;
        if (kind_reg == arpc_pkg::REQ_UPDATE)
        begin
            if (found_reg)
            begin
                upd_we = 1'b1;
            end
            else if (mode_reg != arpc_pkg::MODE_FIND_ONLY)
            begin
                if (have_empty_reg)
                begin
                    upd_we  = 1'b1;
                    upd_idx = empty_idx_reg;
                end
                else if (mode_reg == arpc_pkg::MODE_TRY_HARD && have_old_reg)
                begin
                    upd_we  = 1'b1;
                    upd_idx = old_idx_reg;
                end
            end
        end
    end

    // Map requested state to stored kind; unknown codes store static
    always_comb
    begin
        case (state_reg)
            arpc_pkg::NEW_PENDING: new_kind = arpc_pkg::ENT_PENDING;
            arpc_pkg::NEW_STABLE:  new_kind = arpc_pkg::ENT_STABLE;
            default:               new_kind = arpc_pkg::ENT_STATIC;
        endcase
    end

    // Drive the memory write port
    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        if (cmd.clear)
        begin
            we = 1'b1;
        end
        else if (expire_hit)
        begin
            we    = 1'b1;
            waddr = eval_idx_reg;
        end
        else if (cmd.finish && upd_we)
        begin
            we          = 1'b1;
            waddr       = upd_idx;
            wdata.kind  = new_kind;
            wdata.ip    = ip_reg;
            wdata.mac   = mac_reg;
            wdata.stamp = now_reg;
        end
    end

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.scan)
        begin
            q_reg <= mem[addr_reg];
        end
    end

    // Form the result fields
    assign found_ext = {4'b0000, found_idx_reg};
    assign upd_ext   = {4'b0000, upd_idx};

    always_comb
    begin
        hit_next      = 1'b0;
        resolved_next = 1'b0;
        omac_next     = '0;
        written_next  = 1'b0;
        slot_next     = '0;
        case (kind_reg)
            arpc_pkg::REQ_LOOKUP:
            begin
                hit_next      = found_reg;
                resolved_next = res_reg;
                omac_next     = fmac_reg;
                slot_next     = found_reg ? found_ext[3:0] : '0;
            end
            arpc_pkg::REQ_UPDATE:
            begin
                written_next = upd_we;
                slot_next    = upd_we ? upd_ext[3:0] : '0;
            end
            arpc_pkg::REQ_EXPIRE:
            begin
                written_next = expired_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Hold the result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            hit_reg      <= hit_next;
            resolved_reg <= resolved_next;
            omac_reg     <= omac_next;
            written_reg  <= written_next;
            slot_reg     <= slot_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_hit      = hit_reg;
    assign out_resolved = resolved_reg;
    assign out_mac      = omac_reg;
    assign out_written  = written_reg;
    assign out_slot     = slot_reg;

endmodule

FILE: hdl/arp_cache_table.sv
// Top level of the ARP cache table: stream ports, APB register, controller and datapath.
// Depends on arpc_pkg, arpc_ctrl and arpc_datapath.
`timescale 1ns / 1ps

// Channel   Direction  Signals                                  Carries
// s_axis    in         tvalid tready tdata[119:0] tuser[1:0]    one request
// m_axis    out        tvalid tready tdata[55:0]                one result
// apb       in/out     psel penable pwrite paddr pwdata prdata  pending_timeout
//
// A request is accepted in idle; the scan then reads each entry in turn through a registered
// memory read, a drain state makes the last compare, and a finish state writes back.
// The input stays closed until the controller is back in idle, so the next request is
// not taken before the result of the last one is loaded into the result register.
// After reset a clearing pass writes every entry empty, with
// s_axis_tready low. A result still waiting on m_axis_tready holds the next write-back.

module arp_cache_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,   // ip_addr, mac_addr, new_state, mode, now, pad
    input  logic [1:0]   s_axis_tuser,   // kind
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata    // hit, resolved, found_mac, written, slot, pad
);

    arpc_pkg::arpc_cmd_t cmd;
    arpc_pkg::arpc_sts_t sts;

    logic [arpc_pkg::TMO_W-1:0]  timeout_reg;
    logic                        out_hit;
    logic                        out_resolved;
    logic [arpc_pkg::MAC_W-1:0]  out_mac;
    logic                        out_written;
    logic [arpc_pkg::SLOT_W-1:0] out_slot;

    // Write the timeout register on the access phase
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= arpc_pkg::TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == arpc_pkg::REG_PENDING_TIMEOUT)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == arpc_pkg::REG_PENDING_TIMEOUT) ? {16'd0, timeout_reg}
                                                                 : 32'd0;

    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    arpc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_kind        (s_axis_tuser),
        .req_ip          (s_axis_tdata[31:0]),
        .req_mac         (s_axis_tdata[79:32]),
        .req_state       (s_axis_tdata[81:80]),
        .req_mode        (s_axis_tdata[83:82]),
        .req_now         (s_axis_tdata[115:84]),
        .pending_timeout (timeout_reg),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_hit         (out_hit),
        .out_resolved    (out_resolved),
        .out_mac         (out_mac),
        .out_written     (out_written),
        .out_slot        (out_slot)
    );

    // Pack the result fields
    assign m_axis_tdata = {1'b0, out_slot, out_written, out_mac, out_resolved, out_hit};

`ifndef SYNTHESIS
    // An accepted request keeps the input closed in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while a scan was starting");

    // A new result only follows a cycle with the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a finished scan");

    // A resolved result is always a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("resolved without hit");

    // A hit never comes with a write
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[50]))
        else $error("hit and written both set");
`endif

endmodule
